FILE: rtl/core/qpht_pkg.sv
// Shared constants, request and status codes, and controller/datapath interface types
// for the quadratic-probe hash table. No dependencies.
package qpht_pkg;

  localparam int unsigned TABLE_SLOTS_DEF = 101;
  localparam int unsigned PROBE_LIMIT_DEF = 20;
  localparam int unsigned KEY_BYTES_DEF   = 8;

  localparam int unsigned HASH_MUL  = 19;
  localparam int unsigned PROBE_LIN = 23;

  localparam int unsigned IN_KEY_W = 64;
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned CAP_W    = 7;
  localparam int unsigned SLOT_O_W = 7;
  localparam int unsigned STAT_W   = 3;
  localparam int unsigned LIVE_W   = 7;
  localparam int unsigned OUT_W    = 24;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd101;

  // signed weighted byte sum and its scaled magnitude, sized for eight key bytes
  localparam int unsigned SUM_W    = 14;
  localparam int unsigned MAG_W    = 17;
  localparam int unsigned MOD_CYC  = 2;
  localparam int unsigned MODC_W   = $clog2(MOD_CYC);

  localparam logic [REQ_W-1:0] REQ_FIND   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

  localparam logic [STAT_W-1:0] ST_DONE     = 3'd0;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd1;
  localparam logic [STAT_W-1:0] ST_DUP      = 3'd2;
  localparam logic [STAT_W-1:0] ST_CAP      = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOFREE   = 3'd4;

  typedef struct packed {
    logic clr_en;
    logic load;
    logic hash;
    logic mag;
    logic mod_step;
    logic probe_init;
    logic probe_en;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic mod_last;
    logic probe_done;
    logic out_busy;
  } sts_t;

endpackage

FILE: rtl/core/qpht_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module qpht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/qpht_ctrl.sv
// Sequencing state machine of the hash table: clearing pass, hashing, reduction,
// probing and commit. Uses qpht_pkg command and status types.
module qpht_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_tvalid_i,
  output logic          in_tready_o,
  input  qpht_pkg::sts_t sts_i,
  output qpht_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_HASH   = 3'd2;
  localparam logic [2:0] S_MAG    = 3'd3;
  localparam logic [2:0] S_MOD    = 3'd4;
  localparam logic [2:0] S_PINIT  = 3'd5;
  localparam logic [2:0] S_PROBE  = 3'd6;
  localparam logic [2:0] S_DECIDE = 3'd7;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_tready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_tready_o = 1'b1;
        if (in_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_HASH;
        end
      end
      S_HASH: begin
        cmd_o.hash = 1'b1;
        state_d    = S_MAG;
      end
      S_MAG: begin
        cmd_o.mag = 1'b1;
        state_d   = S_MOD;
      end
      S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_last) state_d = S_PINIT;
      end
      S_PINIT: begin
        cmd_o.probe_init = 1'b1;
        state_d          = S_PROBE;
      end
      S_PROBE: begin
        cmd_o.probe_en = 1'b1;
        if (sts_i.probe_done) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (!sts_i.out_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

endmodule

FILE: rtl/core/qpht_dp.sv
// Datapath of the hash table: key cleanup, hash and modulo reduction, probe address
// generation, slot store, live count and result register. Uses qpht_pkg and qpht_ram.
module qpht_dp #(
  parameter int unsigned TABLE_SLOTS = qpht_pkg::TABLE_SLOTS_DEF,
  parameter int unsigned PROBE_LIMIT = qpht_pkg::PROBE_LIMIT_DEF,
  parameter int unsigned KEY_BYTES   = qpht_pkg::KEY_BYTES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  qpht_pkg::cmd_t                     cmd_i,
  output qpht_pkg::sts_t                     sts_o,
  input  logic [qpht_pkg::IN_KEY_W-1:0]      in_tdata_i,
  input  logic [qpht_pkg::REQ_W-1:0]         in_tuser_i,
  input  logic                               cfg_valid_i,
  input  logic [qpht_pkg::CAP_W-1:0]         cfg_data_i,
  input  logic                               out_tready_i,
  output logic                               out_tvalid_o,
  output logic [qpht_pkg::OUT_W-1:0]         out_tdata_o
);

  localparam int unsigned SlotW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned TotW  = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned CmpW  = (TotW > qpht_pkg::CAP_W) ? TotW : qpht_pkg::CAP_W;
  localparam int unsigned PjW   = $clog2(PROBE_LIMIT + 1);
  localparam int unsigned KeyW  = 8 * KEY_BYTES;
  localparam int unsigned Inc0  = (1 + qpht_pkg::PROBE_LIN) % TABLE_SLOTS;
  localparam int unsigned IncStep = 2 % TABLE_SLOTS;
  localparam logic [SlotW:0] SlotsX = (SlotW + 1)'(TABLE_SLOTS);
  localparam int unsigned RecipSh = qpht_pkg::MAG_W + SlotW;
  localparam int unsigned ProdW   = qpht_pkg::MAG_W + RecipSh;
  localparam longint unsigned RecipFull =
    ((64'd1 << RecipSh) + 64'(TABLE_SLOTS) - 64'd1) / 64'(TABLE_SLOTS);
  localparam logic [RecipSh-1:0] Recip = RecipSh'(RecipFull);

  logic [qpht_pkg::REQ_W-1:0]       req_q;
  logic [KeyW-1:0]                  key_q;
  logic signed [qpht_pkg::SUM_W-1:0] sum_q;
  logic [qpht_pkg::MAG_W-1:0]       mag_q;
  logic [qpht_pkg::MAG_W-1:0]       quot_q;
  logic [SlotW-1:0]                 rem_q, rem_d;
  logic [qpht_pkg::MODC_W-1:0]      modc_q;
  logic [SlotW-1:0]                 addr_q, addr_d, inc_q, inc_d;
  logic [PjW-1:0]                   issued_q;
  logic                             rd_pend_q;
  logic [SlotW-1:0]                 rd_addr_q;
  logic                             found_q, free_q;
  logic [SlotW-1:0]                 found_slot_q, free_slot_q;
  logic [TotW-1:0]                  total_q, total_d;
  logic [qpht_pkg::CAP_W-1:0]       cap_q;
  logic [SlotW-1:0]                 clr_q;
  logic                             out_valid_q;
  logic [qpht_pkg::OUT_W-1:0]       out_data_q;

  logic [KeyW-1:0]                  clean_key;
  logic signed [qpht_pkg::SUM_W-1:0] sum_d;
  logic [qpht_pkg::SUM_W-1:0]       sum_abs;
  logic [qpht_pkg::MAG_W-1:0]       mag_d;
  logic [ProdW-1:0]                 quot_prod;
  logic [qpht_pkg::MAG_W-1:0]       quot_back;
  logic                             issue;
  logic [KeyW:0]                    rdata;
  logic                             rd_match, rd_free;

  logic                             hit_d;
  logic [SlotW-1:0]                 slot_d;
  logic [qpht_pkg::STAT_W-1:0]      status_d;
  logic                             wr_req, wr_valid;
  logic [SlotW-1:0]                 wr_slot;

  logic                             ram_we;
  logic [SlotW-1:0]                 ram_waddr;
  logic [KeyW:0]                    ram_wdata;

  // keep bytes up to the first zero byte
  always_comb begin
    logic alive;
    alive     = 1'b1;
    clean_key = '0;
    for (int i = 0; i < int'(KEY_BYTES); i++) begin
      if (in_tdata_i[8*i +: 8] == 8'h00) alive = 1'b0;
      if (alive) clean_key[8*i +: 8] = in_tdata_i[8*i +: 8];
    end
  end

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < int'(KEY_BYTES); i++) begin
      sum_d = sum_d + qpht_pkg::SUM_W'(signed'(key_q[8*i +: 8]))
                    * signed'(qpht_pkg::SUM_W'(i + 1));
    end
  end

  assign sum_abs = sum_q[qpht_pkg::SUM_W-1] ? qpht_pkg::SUM_W'(-sum_q)
                                             : qpht_pkg::SUM_W'(sum_q);
  assign mag_d   = qpht_pkg::MAG_W'(sum_abs) * qpht_pkg::MAG_W'(qpht_pkg::HASH_MUL);

  // reduce: quotient by reciprocal multiply, then take the remainder
  assign quot_prod = ProdW'(mag_q) * ProdW'(Recip);
  assign quot_back = qpht_pkg::MAG_W'(quot_q * qpht_pkg::MAG_W'(TABLE_SLOTS));
  assign rem_d     = SlotW'(mag_q - quot_back);

  // next probe position: add the running increment, then raise the increment by two
  always_comb begin
    logic [SlotW:0] a, n;
    a = {1'b0, addr_q} + {1'b0, inc_q};
    if (a >= SlotsX) a = a - SlotsX;
    addr_d = a[SlotW-1:0];
    n = {1'b0, inc_q} + (SlotW + 1)'(IncStep);
    if (n >= SlotsX) n = n - SlotsX;
    inc_d = n[SlotW-1:0];
  end

  assign issue    = cmd_i.probe_en && (issued_q != PjW'(PROBE_LIMIT));
  assign rd_match = rdata[KeyW] && (rdata[KeyW-1:0] == key_q);
  assign rd_free  = !rdata[KeyW];

  always_comb begin
    hit_d    = 1'b0;
    slot_d   = '0;
    status_d = qpht_pkg::ST_NOTFOUND;
    wr_req   = 1'b0;
    wr_valid = 1'b0;
    wr_slot  = found_slot_q;
    total_d  = total_q;
    unique case (req_q)
      qpht_pkg::REQ_INSERT: begin
        if (found_q) begin
          status_d = qpht_pkg::ST_DUP;
          slot_d   = found_slot_q;
        end else if (CmpW'(total_q) >= CmpW'(cap_q)) begin
          status_d = qpht_pkg::ST_CAP;
        end else if (free_q) begin
          hit_d    = 1'b1;
          slot_d   = free_slot_q;
          status_d = qpht_pkg::ST_DONE;
          wr_req   = 1'b1;
          wr_valid = 1'b1;
          wr_slot  = free_slot_q;
          total_d  = total_q + TotW'(1);
        end else begin
          status_d = qpht_pkg::ST_NOFREE;
        end
      end
      qpht_pkg::REQ_DELETE: begin
        if (found_q) begin
          hit_d    = 1'b1;
          slot_d   = found_slot_q;
          status_d = qpht_pkg::ST_DONE;
          wr_req   = 1'b1;
          total_d  = total_q - TotW'(1);
        end
      end
      default: begin
        if (found_q) begin
          hit_d    = 1'b1;
          slot_d   = found_slot_q;
          status_d = qpht_pkg::ST_DONE;
        end
      end
    endcase
  end

  assign ram_we    = cmd_i.clr_en || (cmd_i.commit && wr_req);
  assign ram_waddr = cmd_i.clr_en ? clr_q : wr_slot;
  assign ram_wdata = cmd_i.clr_en ? '0 : {wr_valid, key_q};

  qpht_ram #(
    .WIDTH (KeyW + 1),
    .DEPTH (TABLE_SLOTS)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (issue),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      total_q     <= '0;
      cap_q       <= qpht_pkg::CAP_RESET;
      out_valid_q <= 1'b0;
      rd_pend_q   <= 1'b0;
      issued_q    <= '0;
      modc_q      <= '0;
    end else begin
      if (cmd_i.clr_en) clr_q <= clr_q + SlotW'(1);
      if (cfg_valid_i) cap_q <= cfg_data_i;
      if (cmd_i.commit) begin
        total_q     <= total_d;
        out_valid_q <= 1'b1;
      end else if (out_tready_i) begin
        out_valid_q <= 1'b0;
      end
      rd_pend_q <= issue;
      if (cmd_i.probe_init) begin
        issued_q <= '0;
      end else if (issue) begin
        issued_q <= issued_q + PjW'(1);
      end
      if (cmd_i.mag) begin
        modc_q <= '0;
      end else if (cmd_i.mod_step) begin
        modc_q <= modc_q + qpht_pkg::MODC_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_tuser_i;
      key_q <= clean_key;
    end
    if (cmd_i.hash) sum_q <= sum_d;
    if (cmd_i.mag) mag_q <= mag_d;
    if (cmd_i.mod_step) begin
      if (sts_o.mod_last) begin
        rem_q <= rem_d;
      end else begin
        quot_q <= quot_prod[RecipSh +: qpht_pkg::MAG_W];
      end
    end
    if (cmd_i.probe_init) begin
      addr_q  <= rem_q;
      inc_q   <= SlotW'(Inc0);
      found_q <= 1'b0;
      free_q  <= 1'b0;
    end else begin
      if (issue) begin
        addr_q <= addr_d;
        inc_q  <= inc_d;
      end
      if (rd_pend_q && rd_match && !found_q) begin
        found_q      <= 1'b1;
        found_slot_q <= rd_addr_q;
      end
      if (rd_pend_q && rd_free && !free_q) begin
        free_q      <= 1'b1;
        free_slot_q <= rd_addr_q;
      end
    end
    if (issue) rd_addr_q <= addr_q;
    if (cmd_i.commit) begin
      out_data_q <= {{(qpht_pkg::OUT_W - 1 - qpht_pkg::SLOT_O_W - qpht_pkg::STAT_W
                       - qpht_pkg::LIVE_W){1'b0}},
                     qpht_pkg::LIVE_W'(total_d), status_d,
                     qpht_pkg::SLOT_O_W'(slot_d), hit_d};
    end
  end

  assign sts_o.clr_last   = (clr_q == SlotW'(TABLE_SLOTS - 1));
  assign sts_o.mod_last   = (modc_q == qpht_pkg::MODC_W'(qpht_pkg::MOD_CYC - 1));
  assign sts_o.probe_done = (issued_q == PjW'(PROBE_LIMIT));
  assign sts_o.out_busy   = out_valid_q && !out_tready_i;

  assign out_tvalid_o = out_valid_q;
  assign out_tdata_o  = out_data_q;

endmodule

FILE: rtl/core/quadratic_probe_hash_table.sv
// Top level of the quadratic-probe hash table: controller plus datapath.
// Uses qpht_pkg, qpht_ctrl and qpht_dp.
//
// Requests enter on the s_axis channel: tuser holds the request type (find, insert,
// delete), tdata the key bytes, first byte lowest. Each request gives exactly one
// result on the m_axis channel. The capacity register is written through the cfg
// channel, which is always ready; write it only while no request is in flight.
// Each request is loaded, hashed, scaled, reduced modulo the table size (quotient, then
// remainder), walked over PROBE_LIMIT probes (twenty by default), one slot-store read
// per probe, and written back; the next request is taken only after that write-back.
// After reset the slot store is swept clear, one slot a cycle, with s_axis_tready
// low; the live count and the capacity (101) are set at once. A result waits in the
// output register while m_axis_tready is low; the next request is still taken and
// worked on, and is held before its write-back until the register is free.
module quadratic_probe_hash_table #(
  parameter int unsigned TABLE_SLOTS = qpht_pkg::TABLE_SLOTS_DEF,
  parameter int unsigned PROBE_LIMIT = qpht_pkg::PROBE_LIMIT_DEF,
  parameter int unsigned KEY_BYTES   = qpht_pkg::KEY_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [qpht_pkg::IN_KEY_W-1:0] s_axis_tdata,  // key_chars
  input  logic [qpht_pkg::REQ_W-1:0]    s_axis_tuser,  // req_type
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [qpht_pkg::OUT_W-1:0]    m_axis_tdata,  // hit, slot_index, status, live_count
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [qpht_pkg::CAP_W-1:0]    cfg_data_i     // capacity_limit
);

  qpht_pkg::cmd_t cmd;
  qpht_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  qpht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_tvalid_i (s_axis_tvalid),
    .in_tready_o (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  qpht_dp #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .PROBE_LIMIT (PROBE_LIMIT),
    .KEY_BYTES   (KEY_BYTES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_tdata_i   (s_axis_tdata),
    .in_tuser_i   (s_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .out_tready_i (m_axis_tready),
    .out_tvalid_o (m_axis_tvalid),
    .out_tdata_o  (m_axis_tdata)
  );

endmodule

FILE: tb/qpht_checker.sv
// Checker for the quadratic-probe hash table: watches the request, result and
// capacity channels, keeps its own copy of the table and compares every result.
// Depends on qpht_pkg for widths and request/status codes.
module qpht_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [qpht_pkg::IN_KEY_W-1:0] s_axis_tdata,
  input  logic [qpht_pkg::REQ_W-1:0]    s_axis_tuser,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [qpht_pkg::OUT_W-1:0]    m_axis_tdata,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_o,
  input  logic [qpht_pkg::CAP_W-1:0]    cfg_data_i,
  output int                            mismatches_o,
  output int                            outstanding_o
);
  import qpht_pkg::*;

  typedef struct {
    logic                hit;
    logic [SLOT_O_W-1:0] slot;
    logic [STAT_W-1:0]   status;
    logic [LIVE_W-1:0]   live;
  } table_answer_t;

  logic [IN_KEY_W-1:0] stored_key [TABLE_SLOTS_DEF];
  logic                occupied   [TABLE_SLOTS_DEF];
  int unsigned         live_keys;
  logic [CAP_W-1:0]    cap_limit;
  table_answer_t       awaited_answers [$];
  int                  miss_count;

  assign mismatches_o = miss_count;

  function automatic logic [IN_KEY_W-1:0] trim_key(logic [IN_KEY_W-1:0] raw);
    logic [IN_KEY_W-1:0] k;
    k = '0;
    for (int i = 0; i < KEY_BYTES_DEF; i++) begin
      if (raw[8*i +: 8] == 8'd0) break;
      k[8*i +: 8] = raw[8*i +: 8];
    end
    return k;
  endfunction

  function automatic int unsigned home_of(logic [IN_KEY_W-1:0] key);
    logic signed [7:0] b;
    int                sum;
    int unsigned       mag;
    sum = 0;
    for (int i = 0; i < 8; i++) begin
      b = key[8*i +: 8];
      if (b == 8'sd0) break;
      sum += int'(b) * (i + 1);
    end
    sum *= HASH_MUL;
    mag = (sum < 0) ? -sum : sum;
    return mag % TABLE_SLOTS_DEF;
  endfunction

  function automatic int unsigned probe_at(int unsigned home, int unsigned j);
    return (home + j * j + PROBE_LIN * j) % TABLE_SLOTS_DEF;
  endfunction

  function automatic int slot_holding(logic [IN_KEY_W-1:0] key, int unsigned home);
    int unsigned s;
    for (int unsigned j = 0; j < PROBE_LIMIT_DEF; j++) begin
      s = probe_at(home, j);
      if (occupied[s] && stored_key[s] == key) return s;
    end
    return -1;
  endfunction

  function automatic table_answer_t apply_request(logic [REQ_W-1:0] kind,
                                                  logic [IN_KEY_W-1:0] raw);
    logic [IN_KEY_W-1:0] key;
    int unsigned         home;
    int unsigned         s;
    int                  at;
    table_answer_t       r;
    key = trim_key(raw);
    home = home_of(key);
    at = slot_holding(key, home);
    r.hit = 1'b0;
    r.slot = '0;
    r.status = ST_NOTFOUND;
    case (kind)
      REQ_INSERT: begin
        if (at >= 0) begin
          r.status = ST_DUP;
          r.slot = at[SLOT_O_W-1:0];
        end else if (live_keys >= cap_limit) begin
          r.status = ST_CAP;
        end else begin
          r.status = ST_NOFREE;
          for (int unsigned j = 0; j < PROBE_LIMIT_DEF; j++) begin
            s = probe_at(home, j);
            if (!occupied[s]) begin
              occupied[s] = 1'b1;
              stored_key[s] = key;
              live_keys++;
              r.hit = 1'b1;
              r.slot = s[SLOT_O_W-1:0];
              r.status = ST_DONE;
              break;
            end
          end
        end
      end
      REQ_DELETE: begin
        if (at >= 0) begin
          occupied[at] = 1'b0;
          live_keys--;
          r.hit = 1'b1;
          r.slot = at[SLOT_O_W-1:0];
          r.status = ST_DONE;
        end
      end
      default: begin
        if (at >= 0) begin
          r.hit = 1'b1;
          r.slot = at[SLOT_O_W-1:0];
          r.status = ST_DONE;
        end
      end
    endcase
    r.live = live_keys[LIVE_W-1:0];
    return r;
  endfunction

  task automatic report(string field, longint unsigned want, longint unsigned got);
    $display("%0t: mismatch in %s, expected %0d, got %0d", $time, field, want, got);
    miss_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    table_answer_t want;
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_SLOTS_DEF; i++) occupied[i] = 1'b0;
      live_keys = 0;
      cap_limit = CAP_RESET;
      awaited_answers.delete();
      miss_count = 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) cap_limit = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready)
        awaited_answers.push_back(apply_request(s_axis_tuser, s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_answers.size() == 0) begin
          report("result with no request waiting", 0, m_axis_tdata);
        end else begin
          want = awaited_answers.pop_front();
          if (m_axis_tdata[0] !== want.hit) report("hit", want.hit, m_axis_tdata[0]);
          if (m_axis_tdata[7:1] !== want.slot)
            report("slot_index", want.slot, m_axis_tdata[7:1]);
          if (m_axis_tdata[10:8] !== want.status)
            report("status", want.status, m_axis_tdata[10:8]);
          if (m_axis_tdata[17:11] !== want.live)
            report("live_count", want.live, m_axis_tdata[17:11]);
          if (m_axis_tdata[OUT_W-1:18] !== '0)
            report("padding", 0, m_axis_tdata[OUT_W-1:18]);
        end
      end
      outstanding_o <= awaited_answers.size();
    end
  end

endmodule

FILE: tb/tb.sv
// Testbench top for the quadratic-probe hash table: clock, reset, request and
// capacity stimulus, result back-pressure and the verdict.
// Depends on qpht_pkg, quadratic_probe_hash_table and qpht_checker.
module tb;
  import qpht_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_WAIT  = 40;
  localparam int unsigned LONG_HOLD   = 600;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_ITEMS = 64;
  localparam int unsigned POOL_KEYS   = 24;
  localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [IN_KEY_W-1:0] s_axis_tdata  = '0;
  logic [REQ_W-1:0]    s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OUT_W-1:0]    m_axis_tdata;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CAP_W-1:0]    cfg_data_i    = '0;
  int                  mismatches;
  int                  outstanding;
  int unsigned         cycles        = 0;
  logic                send_calm     = 1'b0;

  always #5 clk_i = ~clk_i;

  quadratic_probe_hash_table dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  qpht_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .mismatches_o(mismatches), .outstanding_o(outstanding)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // drain results, with random stalls and two long hold-offs
  initial begin
    int unsigned gap;
    int unsigned taken;
    logic        calm;
    taken = 0;
    calm = 1'b0;
    wait (rst_ni);
    forever begin
      if ($urandom_range(0, 15) == 0) calm = !calm;
      gap = calm ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      taken++;
      if (taken == 60 || taken == 300) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
    end
  end

  task automatic send_request(logic [REQ_W-1:0] kind, logic [IN_KEY_W-1:0] chars);
    int unsigned gap;
    if ($urandom_range(0, 19) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= chars;
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] limit);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= limit;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // terminate a key of len bytes and fill the bytes after it with junk
  function automatic logic [IN_KEY_W-1:0] with_tail(logic [IN_KEY_W-1:0] k, int unsigned len);
    if (len < 8) begin
      k[8*len +: 8] = 8'd0;
      for (int unsigned i = len + 1; i < 8; i++) k[8*i +: 8] = 8'($urandom);
    end
    return k;
  endfunction

  // key whose signed weighted byte sum is target, so all share one home slot
  function automatic logic [IN_KEY_W-1:0] colliding_key(int target);
    logic [IN_KEY_W-1:0] k;
    int unsigned         len;
    int                  rest;
    int                  b;
    do begin
      k = '0;
      len = $urandom_range(2, 5);
      rest = target;
      for (int unsigned i = 1; i < len; i++) begin
        b = $urandom_range(1, 40);
        if ($urandom_range(0, 1)) b = -b;
        k[8*i +: 8] = b[7:0];
        rest -= b * int'(i + 1);
      end
    end while (rest < -128 || rest > 127 || rest == 0);
    k[7:0] = rest[7:0];
    return with_tail(k, len);
  endfunction

  function automatic logic [IN_KEY_W-1:0] scattered_key();
    logic [IN_KEY_W-1:0] k;
    int unsigned         len;
    k = {$urandom, $urandom};
    if ($urandom_range(0, 3) == 0) return k;
    len = $urandom_range(0, 8);
    for (int unsigned i = 0; i < len; i++)
      if (k[8*i +: 8] == 8'd0) k[8*i +: 8] = 8'($urandom_range(1, 255));
    return with_tail(k, len);
  endfunction

  initial begin
    logic [CAP_W-1:0]    phase_caps [PHASES];
    logic [IN_KEY_W-1:0] pool [POOL_KEYS];
    logic [IN_KEY_W-1:0] chars;
    logic [REQ_W-1:0]    kind;
    logic                crowded;
    int                  sum_a;
    int                  sum_b;
    int unsigned         pick;
    int unsigned         insert_share;

    phase_caps = '{7'd127, 7'd5, 7'd101, 7'd40, 7'd0, 7'd101};
    wait (rst_ni);

    send_request(REQ_FIND,   64'h0);
    send_request(REQ_INSERT, 64'h0);
    send_request(REQ_SPARE,  64'hDEAD_BEEF_1234_5600);
    send_request(REQ_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(REQ_INSERT, 64'h8080_8080_8080_8080);
    send_request(REQ_INSERT, 64'h7F7F_7F7F_7F7F_7F7F);
    send_request(REQ_INSERT, 64'hA5C3_9100_0000_4241);
    send_request(REQ_INSERT, 64'h0000_0000_0000_4241);
    send_request(REQ_FIND,   64'h0000_0000_0000_4241);
    send_request(REQ_DELETE, 64'h0000_0000_0000_4241);
    send_request(REQ_DELETE, 64'h0000_0000_0000_4241);
    send_request(REQ_FIND,   64'h0000_0000_0000_4241);
    send_request(REQ_INSERT, 64'h0000_0000_0000_0102);
    send_request(REQ_INSERT, 64'h0000_0000_0000_0004);
    send_request(REQ_DELETE, 64'h0000_0000_0000_0102);
    send_request(REQ_FIND,   64'h0000_0000_0000_0004);
    write_capacity(7'd0);
    send_request(REQ_INSERT, 64'h0000_0000_0000_0033);
    send_request(REQ_INSERT, 64'h7700_0000_0000_0000);
    write_capacity(7'd5);
    send_request(REQ_INSERT, 64'h0000_0000_0000_0033);
    write_capacity(7'd6);
    send_request(REQ_INSERT, 64'h0000_0000_0000_0033);
    send_request(REQ_INSERT, 64'h0000_0000_0000_0034);

    for (int unsigned p = 0; p < PHASES; p++) begin
      write_capacity(phase_caps[p]);
      crowded = (p % 2 == 0);
      sum_a = int'($urandom_range(0, 400)) - 200;
      sum_b = int'($urandom_range(0, 400)) - 200;
      for (int unsigned i = 0; i < POOL_KEYS; i++)
        pool[i] = !crowded ? scattered_key() :
                  (i < 20) ? colliding_key(sum_a) : colliding_key(sum_b);
      insert_share = crowded ? 55 : 40;
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        kind = (pick < insert_share)      ? REQ_INSERT :
               (pick < insert_share + 20) ? REQ_FIND   :
               (pick < 95)                ? REQ_DELETE : REQ_SPARE;
        chars = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, POOL_KEYS - 1)]
                                             : scattered_key();
        send_request(kind, chars);
      end
    end

    settle();
    if (mismatches == 0 && outstanding == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/qpht_pkg.sv
rtl/core/qpht_ram.sv
rtl/core/qpht_ctrl.sv
rtl/core/qpht_dp.sv
rtl/core/quadratic_probe_hash_table.sv
tb/qpht_checker.sv
tb/tb.sv
